// ===== src/fcq_pkg.sv =====
// fcq_pkg: shared types and codes for the countdown queue.
// Record layout, cell control bundle, opcodes and status codes.
// No dependencies.
package fcq_pkg;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] count;
        logic [7:0]  kind;
        logic [15:0] version;
    } rec_t;

    typedef struct packed {
        logic shift;
        logic enq;
        logic dec;
        rec_t entry;
    } ctrl_t;

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEC = 2'd1;
    localparam logic [1:0] OP_DEQ = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== src/fcq_cell.sv =====
// fcq_cell: one slot of the shifting queue; holds a record and its valid flag.
// Takes its neighbor's record on a shift, loads a new record when it is the first free slot,
// and decrements its count when dec_en is set. Depends on fcq_pkg.
module fcq_cell
    import fcq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  ctrl_t ctrl,
    input  logic  dec_en,
    input  logic  prev_valid,
    input  logic  nb_valid,
    input  rec_t  nb_rec,
    output logic  valid_o,
    output rec_t  rec_o
);

    logic valid_reg, valid_next;
    rec_t rec_reg, rec_next;

    always_comb begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctrl.shift) begin
            valid_next = nb_valid;
            rec_next   = nb_rec;
        end else if (ctrl.enq && !valid_reg && prev_valid) begin
            valid_next = 1'b1;
            rec_next   = ctrl.entry;
        end else if (dec_en) begin
            rec_next.count = rec_reg.count - 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign valid_o = valid_reg;
    assign rec_o   = rec_reg;

endmodule

// ===== src/fifo_countdown_queue.sv =====
// fifo_countdown_queue: record queue with enqueue, dequeue and head countdown.
// Row of fcq_cell slots, head in slot 0, plus a result register. Uses fcq_pkg.
//
//  channel | dir | ports                                      | transfer
//  s_      | in  | opcode, entry_id/count/type/version        | s_valid & s_ready
//  m_      | out | status, out_*, remaining, head_id, is_empty | m_valid & m_ready
//
// Each item passes S_IDLE, which accepts it and updates the cell row, then S_FIN, which
// reads slot 0 for the head id and loads the result register.
// The result register frees the input side; a stalled result holds only the
// S_FIN step of the next item.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
module fifo_countdown_queue
    import fcq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [15:0] s_entry_id,
    input  logic [15:0] s_entry_count,
    input  logic [7:0]  s_entry_type,
    input  logic [15:0] s_entry_version,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_out_id,
    output logic [15:0] m_out_count,
    output logic [7:0]  m_out_type,
    output logic [15:0] m_out_version,
    output logic [15:0] m_remaining,
    output logic [15:0] m_head_id,
    output logic        m_is_empty
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIN  = 1'b1;

    logic state_reg, state_next;

    logic [1:0] st_reg, st_next;
    rec_t       orec_reg, orec_next;
    logic [15:0] rem_reg, rem_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg;
    rec_t        m_rec_reg;
    logic [15:0] m_rem_reg;
    logic [15:0] m_head_reg;
    logic        m_empty_reg;

    logic [DEPTH-1:0] valid_w;
    rec_t             rec_w [DEPTH];
    ctrl_t            ctrl;
    logic             accept;
    logic             load_out;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl.shift         = 1'b0;
        ctrl.enq           = 1'b0;
        ctrl.dec           = 1'b0;
        ctrl.entry.id      = s_entry_id;
        ctrl.entry.count   = s_entry_count;
        ctrl.entry.kind    = s_entry_type;
        ctrl.entry.version = s_entry_version;
        st_next   = st_reg;
        orec_next = orec_reg;
        rem_next  = rem_reg;
        if (accept) begin
            st_next   = ST_OK;
            orec_next = '0;
            rem_next  = '0;
            case (s_opcode)
                OP_ENQ: begin
                    if (valid_w[DEPTH-1]) begin
                        st_next = ST_FULL;
                    end else begin
                        ctrl.enq = 1'b1;
                    end
                end
                OP_DEC: begin
                    if (!valid_w[0]) begin
                        st_next = ST_EMPTY;
                    end else if (rec_w[0].count <= 16'd1) begin
                        ctrl.shift = 1'b1;
                    end else begin
                        ctrl.dec = 1'b1;
                        rem_next = rec_w[0].count - 16'd1;
                    end
                end
                OP_DEQ: begin
                    if (!valid_w[0]) begin
                        st_next = ST_EMPTY;
                    end else begin
                        ctrl.shift = 1'b1;
                        orec_next  = rec_w[0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg   <= st_next;
        orec_reg <= orec_next;
        rem_reg  <= rem_next;
        if (load_out) begin
            m_status_reg <= st_reg;
            m_rec_reg    <= orec_reg;
            m_rem_reg    <= rem_reg;
            m_head_reg   <= valid_w[0] ? rec_w[0].id : 16'd0;
            m_empty_reg  <= !valid_w[0];
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic prev_v;
        logic nb_v;
        rec_t nb_r;
        logic dec_e;

        if (i == 0) begin : g_head
            assign prev_v = 1'b1;
            assign dec_e  = ctrl.dec;
        end else begin : g_body
            assign prev_v = valid_w[i-1];
            assign dec_e  = 1'b0;
        end

        if (i == DEPTH - 1) begin : g_tail
            assign nb_v = 1'b0;
            assign nb_r = '0;
        end else begin : g_link
            assign nb_v = valid_w[i+1];
            assign nb_r = rec_w[i+1];
        end

        fcq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .dec_en     (dec_e),
            .prev_valid (prev_v),
            .nb_valid   (nb_v),
            .nb_rec     (nb_r),
            .valid_o    (valid_w[i]),
            .rec_o      (rec_w[i])
        );
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_id      = m_rec_reg.id;
    assign m_out_count   = m_rec_reg.count;
    assign m_out_type    = m_rec_reg.kind;
    assign m_out_version = m_rec_reg.version;
    assign m_remaining   = m_rem_reg;
    assign m_head_id     = m_head_reg;
    assign m_is_empty    = m_empty_reg;

`ifndef ASSERT_OFF
    a_thermometer: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_w[DEPTH-1:1] & ~valid_w[DEPTH-2:0]) == '0)
        else $error("occupied slots are not contiguous from the head");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_opcode == OP_ENQ && !valid_w[DEPTH-1])
        |=> $countones(valid_w) == $past($countones(valid_w)) + 1)
        else $error("enqueue transfer did not add one record");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> m_is_empty)
        else $error("empty status reported with records present");
`endif

endmodule

// ===== dv/fifo_countdown_queue_tb.sv =====
`timescale 1ns / 1ps
// fifo_countdown_queue_tb: self-checking bench for the record queue with head countdown.
// Scoreboard class models the queue of records; tasks drive the s_ channel, an always block
// drains and checks the m_ channel. Depends on fcq_pkg and fifo_countdown_queue.

import fcq_pkg::*;

typedef struct packed {
    logic [1:0]  status;
    rec_t        removed;
    logic [15:0] remaining;
    logic [15:0] head_id;
    logic        is_empty;
} reply_t;

class queue_scoreboard;
    int     depth;
    rec_t   held[$];
    reply_t expected[$];
    int     errors;
    int     n_ops[4];
    int     n_full;
    int     n_empty;
    int     n_expired;
    int     peak;

    function new(int depth_i);
        depth = depth_i;
        errors = 0;
        n_full = 0;
        n_empty = 0;
        n_expired = 0;
        peak = 0;
        foreach (n_ops[i]) n_ops[i] = 0;
    endfunction

    function int pending();
        return expected.size();
    endfunction

    // apply one accepted request to the queue image and queue its reply
    function void note_request(logic [1:0] op, rec_t entry);
        reply_t r;
        rec_t   head;
        r = '0;
        case (op)
            OP_ENQ: begin
                if (held.size() >= depth) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    held.push_back(entry);
                end
            end
            OP_DEC: begin
                if (held.size() == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    head = held[0];
                    if (head.count <= 16'd1) begin
                        void'(held.pop_front());
                        n_expired++;
                    end else begin
                        head.count = head.count - 16'd1;
                        held[0] = head;
                        r.remaining = head.count;
                    end
                end
            end
            OP_DEQ: begin
                if (held.size() == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    r.removed = held.pop_front();
                end
            end
            default: ;
        endcase
        r.is_empty = (held.size() == 0);
        r.head_id = r.is_empty ? 16'd0 : held[0].id;
        if (held.size() > peak) peak = held.size();
        n_ops[op]++;
        expected.push_back(r);
    endfunction

    function int field_diff(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    function void check_result(reply_t got);
        reply_t want;
        if (expected.size() == 0) begin
            $error("result transfer with no request outstanding");
            errors++;
            return;
        end
        want = expected.pop_front();
        errors += field_diff("status", want.status, got.status);
        errors += field_diff("out_id", want.removed.id, got.removed.id);
        errors += field_diff("out_count", want.removed.count, got.removed.count);
        errors += field_diff("out_type", want.removed.kind, got.removed.kind);
        errors += field_diff("out_version", want.removed.version, got.removed.version);
        errors += field_diff("remaining", want.remaining, got.remaining);
        errors += field_diff("head_id", want.head_id, got.head_id);
        errors += field_diff("is_empty", want.is_empty, got.is_empty);
    endfunction
endclass

module fifo_countdown_queue_tb;

    localparam int         QUEUE_DEPTH = 16;
    localparam int         N_RANDOM    = 1300;
    localparam int         CYCLE_LIMIT = 300000;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = OP_ENQ;
    logic [15:0] s_entry_id = '0;
    logic [15:0] s_entry_count = '0;
    logic [7:0]  s_entry_type = '0;
    logic [15:0] s_entry_version = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_out_id;
    logic [15:0] m_out_count;
    logic [7:0]  m_out_type;
    logic [15:0] m_out_version;
    logic [15:0] m_remaining;
    logic [15:0] m_head_id;
    logic        m_is_empty;

    reply_t          dut_reply;
    queue_scoreboard sb;
    int              cycles = 0;
    int              rx_mode = 0;

    assign dut_reply = {m_status, m_out_id, m_out_count, m_out_type, m_out_version,
                        m_remaining, m_head_id, m_is_empty};

    fifo_countdown_queue #(.DEPTH(QUEUE_DEPTH)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_entry_id      (s_entry_id),
        .s_entry_count   (s_entry_count),
        .s_entry_type    (s_entry_type),
        .s_entry_version (s_entry_version),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_id        (m_out_id),
        .m_out_count     (m_out_count),
        .m_out_type      (m_out_type),
        .m_out_version   (m_out_version),
        .m_remaining     (m_remaining),
        .m_head_id       (m_head_id),
        .m_is_empty      (m_is_empty)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check on transfer, then pick the next ready level
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_result(dut_reply);
            if (cycles % 97 == 0) rx_mode <= int'($urandom_range(0, 3));
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 7) != 0);
                default: m_ready <= ((cycles % 12) >= 5);
            endcase
        end
    end

    function automatic rec_t make_rec(logic [15:0] id, logic [15:0] count,
                                      logic [7:0] kind, logic [15:0] version);
        rec_t r;
        r.id = id;
        r.count = count;
        r.kind = kind;
        r.version = version;
        return r;
    endfunction

    // short countdowns dominate so decrements actually expire records
    function automatic rec_t random_rec();
        int          pick;
        logic [15:0] count;
        pick = $urandom_range(0, 9);
        if (pick < 5) count = 16'($urandom_range(0, 3));
        else if (pick < 7) count = 16'($urandom_range(0, 20));
        else count = 16'($urandom);
        return make_rec(16'($urandom), count, 8'($urandom), 16'($urandom));
    endfunction

    task automatic send_item(logic [1:0] op, rec_t entry);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_entry_id <= entry.id;
        s_entry_count <= entry.count;
        s_entry_type <= entry.kind;
        s_entry_version <= entry.version;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(op, entry);
    endtask

    // one call per transfer at most, so s_valid sees a single update per step
    task automatic pause_sender(int gap, bit drain);
        if (drain && gap == 0) gap = 1;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            while (drain && sb.pending() != 0) @(posedge aclk);
        end
    endtask

    initial begin
        rec_t ones;
        rec_t zeros;
        int   sent;
        int   phase;
        int   phase_len;
        int   enq_pct;
        int   burst_left;
        int   pick;
        bit   quiet;
        bit   last;
        logic [1:0] op;

        sb = new(QUEUE_DEPTH);
        ones = make_rec(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        zeros = make_rec(16'h0, 16'h0, 8'h0, 16'h0);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-queue ops, unused opcode, extreme records, zero countdown
        send_item(OP_DEQ, zeros);
        send_item(OP_DEC, zeros);
        send_item(OP_UNUSED, ones);
        send_item(OP_ENQ, ones);
        send_item(OP_ENQ, zeros);
        send_item(OP_DEC, zeros);
        send_item(OP_UNUSED, zeros);
        pause_sender(2, 0);
        send_item(OP_DEQ, ones);
        send_item(OP_DEC, ones);
        // fill to capacity, then one refused enqueue
        repeat (QUEUE_DEPTH) begin
            send_item(OP_ENQ, make_rec(16'($urandom), 16'($urandom_range(1, 2)),
                                       8'($urandom), 16'($urandom)));
        end
        send_item(OP_ENQ, ones);
        pause_sender(1, 1);

        sent = 0;
        phase = 0;
        burst_left = $urandom_range(1, 24);
        while (sent < N_RANDOM) begin
            phase_len = $urandom_range(40, 150);
            case (phase % 5)
                0: enq_pct = 85;
                1: enq_pct = 50;
                2: enq_pct = 25;
                3: enq_pct = 60;
                default: enq_pct = 15;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len && sent < N_RANDOM; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) op = OP_UNUSED;
                else if (pick < 3 + enq_pct) op = OP_ENQ;
                else if ($urandom_range(0, 9) < 6) op = OP_DEC;
                else op = OP_DEQ;
                send_item(op, random_rec());
                sent++;
                burst_left--;
                last = (i == phase_len - 1) || (sent == N_RANDOM);
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    pause_sender(quiet ? 0 : $urandom_range(1, 6),
                                 last && (phase == 2 || $urandom_range(0, 4) == 0));
                end else begin
                    pause_sender(0, last && (phase == 2 || $urandom_range(0, 4) == 0));
                end
            end
            phase++;
        end

        pause_sender(1, 1);
        repeat (16) @(posedge aclk);

        $display("Covered %0d enqueue, %0d decrement, %0d dequeue, %0d unused-opcode transfers.",
                 sb.n_ops[OP_ENQ], sb.n_ops[OP_DEC], sb.n_ops[OP_DEQ], sb.n_ops[OP_UNUSED]);
        $display("Saw %0d full refusals, %0d empty replies, %0d countdown expiries, peak fill %0d.",
                 sb.n_full, sb.n_empty, sb.n_expired, sb.peak);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
